>>> hw/rtl/rtpb_pkg.sv
// Shared types, codes and default sizes for the real-time priority bank core selector.
package rtpb_pkg;

    localparam int NUM_CORES_DEF   = 8;
    localparam int BANK_WIDTH_DEF  = 16;
    localparam int PRIO_LEVELS_DEF = 100;

    localparam int FUNC_W     = 2;
    localparam int CORE_W     = 3;
    localparam int PRIO_W     = 7;
    localparam int MASK_W     = 8;
    localparam int SCORE_W    = 17;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SELECT = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FALLBACK = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_SAT      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CORES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_CORES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ASYM_ENABLE  = 2'd2;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_DECODE,
        CS_MODIFY,
        CS_SCAN,
        CS_DRAIN,
        CS_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic rd_core;
        logic upd;
        logic set_direct;
        logic scan_step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_select;
        logic direct;
        logic scan_last;
        logic out_free;
    } dp_stat_t;

endpackage

>>> hw/rtl/rtpb_ctrl.sv
// Controller state machine sequencing bank updates and the selection scan.
module rtpb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rtpb_pkg::dp_stat_t  stat,
    output rtpb_pkg::ctrl_cmd_t cmd
);
    import rtpb_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            CS_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = CS_DECODE;
                end
            end
            CS_DECODE: begin
                if (stat.direct) begin
                    cmd.set_direct = 1'b1;
                    state_next     = CS_RESULT;
                end else if (stat.is_select) begin
                    state_next = CS_SCAN;
                end else begin
                    cmd.rd_core = 1'b1;
                    state_next  = CS_MODIFY;
                end
            end
            CS_MODIFY: begin
                cmd.upd    = 1'b1;
                state_next = CS_RESULT;
            end
            CS_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = CS_DRAIN;
                end
            end
            CS_DRAIN: begin
                state_next = CS_RESULT;
            end
            CS_RESULT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/rtpb_dp.sv
// Datapath: configuration registers, bank memory, saturating update, scan compare, output register.
module rtpb_dp #(
    parameter int NUM_CORES   = rtpb_pkg::NUM_CORES_DEF,
    parameter int BANK_WIDTH  = rtpb_pkg::BANK_WIDTH_DEF,
    parameter int PRIO_LEVELS = rtpb_pkg::PRIO_LEVELS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rtpb_pkg::ctrl_cmd_t             cmd,
    output rtpb_pkg::dp_stat_t              stat,
    input  logic [rtpb_pkg::FUNC_W-1:0]     s_func,
    input  logic [rtpb_pkg::CORE_W-1:0]     s_core,
    input  logic [rtpb_pkg::PRIO_W-1:0]     s_task_prio,
    input  logic [rtpb_pkg::MASK_W-1:0]     s_allowed_cores,
    input  logic [rtpb_pkg::CORE_W-1:0]     s_prev_core,
    input  logic                            s_task_queued,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rtpb_pkg::CORE_W-1:0]     m_chosen_core,
    output logic [rtpb_pkg::SCORE_W-1:0]    m_score,
    output logic [rtpb_pkg::STATUS_W-1:0]   m_status,
    input  logic                            cfg_we,
    input  logic [rtpb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rtpb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rtpb_pkg::*;

    localparam int MASK_CORES = (NUM_CORES < MASK_W) ? NUM_CORES : MASK_W;
    localparam int IDX_W      = $clog2(NUM_CORES);
    localparam int SIDX_W     = $clog2(MASK_CORES);
    localparam int WT_W       = $clog2(PRIO_LEVELS + 1);
    localparam int BW1        = BANK_WIDTH + 1;

    logic [MASK_CORES-1:0] active_reg;
    logic [MASK_CORES-1:0] fast_reg;
    logic                  asym_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '1;
            fast_reg   <= '1;
            asym_reg   <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ACTIVE_CORES: active_reg <= cfg_wdata[MASK_CORES-1:0];
                CFG_FAST_CORES:   fast_reg   <= cfg_wdata[MASK_CORES-1:0];
                CFG_ASYM_ENABLE:  asym_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // transaction capture
    logic [8:0]            prio_ext;
    logic [8:0]            levels_ext;
    logic [8:0]            weight9;
    logic [MASK_CORES-1:0] allow_in;
    logic [MASK_CORES-1:0] cand_in;
    logic [MASK_CORES-1:0] cand_fast;
    logic [CORE_W-1:0]     first_in;

    assign prio_ext   = 9'(s_task_prio);
    assign levels_ext = 9'(PRIO_LEVELS);
    assign weight9    = (prio_ext >= levels_ext) ? 9'd0 : (levels_ext - prio_ext);
    assign allow_in   = s_allowed_cores[MASK_CORES-1:0];
    assign cand_in    = allow_in & active_reg;
    assign cand_fast  = cand_in & fast_reg;

    always_comb begin
        first_in = '0;
        for (int i = MASK_CORES - 1; i >= 0; i--) begin
            if (allow_in[i]) begin
                first_in = CORE_W'(i);
            end
        end
    end

    logic [FUNC_W-1:0]     func_reg;
    logic [CORE_W-1:0]     core_reg;
    logic [WT_W-1:0]       weight_reg;
    logic [CORE_W-1:0]     prev_reg;
    logic                  queued_reg;
    logic [MASK_CORES-1:0] cand_reg;
    logic                  allow_zero_reg;
    logic                  cand_zero_reg;
    logic [CORE_W-1:0]     first_reg;
    logic                  oob_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg       <= s_func;
            core_reg       <= s_core;
            weight_reg     <= WT_W'(weight9);
            prev_reg       <= s_prev_core;
            queued_reg     <= s_task_queued;
            cand_reg       <= (asym_reg && (cand_fast != '0)) ? cand_fast : cand_in;
            allow_zero_reg <= (allow_in == '0);
            cand_zero_reg  <= (cand_in == '0);
            first_reg      <= first_in;
            oob_reg        <= (32'(s_core) >= NUM_CORES);
        end
    end

    // bank memory with per-entry valid bits; an entry never written reads as zero
    logic [BANK_WIDTH-1:0] bank_mem [NUM_CORES];
    logic [NUM_CORES-1:0]  bank_vld_reg;
    logic [BANK_WIDTH-1:0] rd_data_reg;
    logic [SIDX_W-1:0]     scan_idx_reg;
    logic [SIDX_W-1:0]     cmp_idx_reg;
    logic                  cmp_vld_reg;
    logic [IDX_W-1:0]      core_idx;
    logic [IDX_W-1:0]      rd_addr;
    logic                  rd_en;

    assign core_idx = IDX_W'(core_reg);
    assign rd_addr  = cmd.rd_core ? core_idx : IDX_W'(scan_idx_reg);
    assign rd_en    = cmd.rd_core | cmd.scan_step;

    logic [BW1-1:0]        wt_ext;
    logic [BW1-1:0]        sum_ext;
    logic [BW1-1:0]        diff_ext;
    logic                  add_sat;
    logic                  rem_sat;
    logic                  mod_sat;
    logic [BANK_WIDTH-1:0] bank_new;

    assign wt_ext   = BW1'(weight_reg);
    assign sum_ext  = {1'b0, rd_data_reg} + wt_ext;
    assign diff_ext = {1'b0, rd_data_reg} - wt_ext;
    assign add_sat  = sum_ext[BANK_WIDTH];
    assign rem_sat  = ({1'b0, rd_data_reg} < wt_ext);
    assign mod_sat  = (func_reg == FUNC_ADD) ? add_sat : rem_sat;

    always_comb begin
        if (func_reg == FUNC_ADD) begin
            bank_new = add_sat ? '1 : sum_ext[BANK_WIDTH-1:0];
        end else begin
            bank_new = rem_sat ? '0 : diff_ext[BANK_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.upd) begin
            bank_mem[core_idx] <= bank_new;
        end
        if (rd_en) begin
            rd_data_reg <= bank_vld_reg[rd_addr] ? bank_mem[rd_addr] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_vld_reg <= '0;
        end else if (cmd.upd) begin
            bank_vld_reg[core_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            cmp_idx_reg  <= '0;
        end else begin
            cmp_vld_reg <= cmd.scan_step;
            cmp_idx_reg <= scan_idx_reg;
            if (cmd.load) begin
                scan_idx_reg <= '0;
            end else if (cmd.scan_step) begin
                scan_idx_reg <= scan_idx_reg + SIDX_W'(1);
            end
        end
    end

    // result registers, also the running best of the scan
    logic [CORE_W-1:0]   res_core_reg;
    logic [BW1-1:0]      res_score_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                found_reg;
    logic                skip_wt;
    logic [BW1-1:0]      scan_score;
    logic                take;
    logic                direct;
    logic [CORE_W-1:0]   dir_core;
    logic [STATUS_W-1:0] dir_status;

    assign skip_wt    = queued_reg && (prev_reg == CORE_W'(cmp_idx_reg));
    assign scan_score = {1'b0, rd_data_reg} + (skip_wt ? '0 : wt_ext);
    assign take       = cmp_vld_reg && cand_reg[cmp_idx_reg]
                        && (!found_reg || (scan_score < res_score_reg));

    always_comb begin
        direct     = 1'b1;
        dir_core   = '0;
        dir_status = STAT_OK;
        unique case (func_reg) inside
            FUNC_ADD, FUNC_REMOVE: begin
                direct   = oob_reg;
                dir_core = core_reg;
            end
            FUNC_SELECT: begin
                direct = allow_zero_reg | cand_zero_reg;
                if (allow_zero_reg) begin
                    dir_status = STAT_EMPTY;
                end else begin
                    dir_core   = first_reg;
                    dir_status = STAT_FALLBACK;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            found_reg      <= 1'b0;
            res_status_reg <= STAT_OK;
        end else if (cmd.set_direct) begin
            res_core_reg   <= dir_core;
            res_score_reg  <= '0;
            res_status_reg <= dir_status;
        end else if (cmd.upd) begin
            res_core_reg   <= core_reg;
            res_score_reg  <= {1'b0, bank_new};
            res_status_reg <= mod_sat ? STAT_SAT : STAT_OK;
        end else if (take) begin
            found_reg     <= 1'b1;
            res_core_reg  <= CORE_W'(cmp_idx_reg);
            res_score_reg <= scan_score;
        end
    end

    // output register
    logic                m_valid_reg;
    logic [CORE_W-1:0]   m_core_reg;
    logic [SCORE_W-1:0]  m_score_reg;
    logic [STATUS_W-1:0] m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_core_reg   <= res_core_reg;
            m_score_reg  <= SCORE_W'(res_score_reg);
            m_status_reg <= res_status_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_chosen_core = m_core_reg;
    assign m_score       = m_score_reg;
    assign m_status      = m_status_reg;

    assign stat.is_select = (func_reg == FUNC_SELECT);
    assign stat.direct    = direct;
    assign stat.scan_last = (scan_idx_reg == SIDX_W'(MASK_CORES - 1));
    assign stat.out_free  = !m_valid_reg || m_ready;

endmodule

>>> hw/rtl/rt_priority_bank_core_selector_top.sv
// Top level of the real-time priority bank and least-loaded core selector.
// Each transaction produces exactly one result. An add or remove is sequenced as decode and
// bank read, saturating update and write back, then result; a select that scans reads the
// banks of the maskable cores in turn and then yields its result; a transaction answered
// without the banks (core out of range, empty or inactive allowed set, unused function)
// goes from decode straight to the result. The controller returns to idle before the next
// accept. The scan reads one bank per cycle through the single read port of the bank memory.
// A new transaction is accepted as soon as the previous result sits in the output register,
// even while that result still waits on m_ready. Configuration registers take effect for
// transactions accepted after the write.
module rt_priority_bank_core_selector_top #(
    parameter int NUM_CORES   = rtpb_pkg::NUM_CORES_DEF,
    parameter int BANK_WIDTH  = rtpb_pkg::BANK_WIDTH_DEF,
    parameter int PRIO_LEVELS = rtpb_pkg::PRIO_LEVELS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [rtpb_pkg::FUNC_W-1:0]     s_func,
    input  logic [rtpb_pkg::CORE_W-1:0]     s_core,
    input  logic [rtpb_pkg::PRIO_W-1:0]     s_task_prio,
    input  logic [rtpb_pkg::MASK_W-1:0]     s_allowed_cores,
    input  logic [rtpb_pkg::CORE_W-1:0]     s_prev_core,
    input  logic                            s_task_queued,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rtpb_pkg::CORE_W-1:0]     m_chosen_core,
    output logic [rtpb_pkg::SCORE_W-1:0]    m_score,
    output logic [rtpb_pkg::STATUS_W-1:0]   m_status,
    input  logic                            cfg_we,
    input  logic [rtpb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rtpb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rtpb_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    rtpb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rtpb_dp #(
        .NUM_CORES   (NUM_CORES),
        .BANK_WIDTH  (BANK_WIDTH),
        .PRIO_LEVELS (PRIO_LEVELS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_func          (s_func),
        .s_core          (s_core),
        .s_task_prio     (s_task_prio),
        .s_allowed_cores (s_allowed_cores),
        .s_prev_core     (s_prev_core),
        .s_task_queued   (s_task_queued),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_chosen_core   (m_chosen_core),
        .m_score         (m_score),
        .m_status        (m_status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

endmodule

>>> hw/rtl/rtpb_checker.sv
// Port-level checker for the core selector and its bind to the top level.
module rtpb_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [rtpb_pkg::CORE_W-1:0]   m_chosen_core,
    input logic [rtpb_pkg::SCORE_W-1:0]  m_score,
    input logic [rtpb_pkg::STATUS_W-1:0] m_status
);
    import rtpb_pkg::*;

    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("transaction accepted while previous one in progress");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_chosen_core) && $stable(m_score)
            && $stable(m_status))
        else $error("stalled result changed");

    a_empty_set_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STAT_EMPTY) |-> (m_chosen_core == '0) && (m_score == '0))
        else $error("empty allowed set result not zero");

    a_fallback_score: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STAT_FALLBACK) |-> (m_score == '0))
        else $error("fallback result carries a score");

endmodule

bind rt_priority_bank_core_selector_top rtpb_checker u_rtpb_checker (.*);
